@@ hdl/gdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdc_pkg
// shared widths, register codes, reset values and pipeline types of the
// gamepad dead zone conditioner
// ----------------------------------------------------------------------------
package gdc_pkg;

    localparam int AXIS_FULL_SCALE_DEF = 32767;
    localparam int NUM_SLOTS_DEF       = 4;

    localparam int AXIS_W    = 16;
    localparam int DZ_W      = 15;
    localparam int TRIG_W    = 8;
    localparam int CFG_W     = 15;
    localparam int SQ_VAL_W  = 32;
    localparam int ROOT_W    = 16;
    localparam int SQ_REM_W  = 17;
    localparam int QUO_W     = 16;
    localparam int DEN_W     = 31;
    localparam int NUM_W     = 47;
    localparam int TNUM_W    = 24;
    localparam int NUM_STICK = 2;
    localparam int NUM_AXIS  = 4;

    localparam logic [1:0] REG_LEFT_DZ  = 2'd0;
    localparam logic [1:0] REG_RIGHT_DZ = 2'd1;
    localparam logic [1:0] REG_TRIG_THR = 2'd2;

    localparam logic [DZ_W-1:0]   LEFT_DZ_RST  = 15'd7849;
    localparam logic [DZ_W-1:0]   RIGHT_DZ_RST = 15'd8689;
    localparam logic [TRIG_W-1:0] TRIG_THR_RST = 8'd30;
    localparam logic [TRIG_W-1:0] TRIG_TOP     = 8'd255;

    typedef struct packed {
        logic                               valid;
        logic [1:0]                         slot;
        logic                               present;
        logic [NUM_AXIS-1:0][AXIS_W-1:0]    axis;
        logic [NUM_STICK-1:0][TRIG_W-1:0]   trig;
        logic [15:0]                        buttons;
    } t_side;

    typedef struct packed {
        logic                               valid;
        logic [1:0]                         slot;
        logic                               present;
        logic [NUM_AXIS-1:0]                neg;
        logic [NUM_AXIS-1:0]                zero;
        logic [NUM_STICK-1:0]               sat;
        logic [NUM_AXIS-1:0]                ovf;
        logic [NUM_STICK-1:0][TRIG_W-1:0]   trig;
        logic [NUM_STICK-1:0]               tzero;
        logic [15:0]                        buttons;
    } t_meta;

endpackage

@@ hdl/gdc_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdc_sqrt_cell
// one digit of a restoring integer square root, two radicand bits per cell
// ----------------------------------------------------------------------------
module gdc_sqrt_cell import gdc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [SQ_REM_W-1:0] i_rem,
    input  logic [ROOT_W-1:0]   i_root,
    input  logic [SQ_VAL_W-1:0] i_val,
    output logic [SQ_REM_W-1:0] o_rem,
    output logic [ROOT_W-1:0]   o_root,
    output logic [SQ_VAL_W-1:0] o_val
);

    logic [SQ_REM_W+1:0] w_rem2;
    logic [SQ_REM_W+1:0] w_trial;
    logic                w_ge;
    logic [SQ_REM_W-1:0] n_rem;
    logic [SQ_REM_W-1:0] r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [SQ_VAL_W-1:0] r_val;

    always_comb begin
        w_rem2  = {i_rem, i_val[SQ_VAL_W-1 -: 2]};
        w_trial = {{(SQ_REM_W-ROOT_W){1'b0}}, i_root, 2'b01};
        w_ge    = (w_rem2 >= w_trial);
        n_rem   = w_ge ? SQ_REM_W'(w_rem2 - w_trial) : SQ_REM_W'(w_rem2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= {i_root[ROOT_W-2:0], w_ge};
            r_val  <= {i_val[SQ_VAL_W-3:0], 2'b00};
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_val  = r_val;

endmodule

@@ hdl/gdc_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdc_div_cell
// one quotient bit of a restoring unsigned divide; divisor rides along
// ----------------------------------------------------------------------------
module gdc_div_cell import gdc_pkg::*; #(
    parameter int W = DEN_W
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [W-1:0]     i_rem,
    input  logic [W-1:0]     i_den,
    input  logic [QUO_W-1:0] i_num,
    input  logic [QUO_W-1:0] i_quo,
    output logic [W-1:0]     o_rem,
    output logic [W-1:0]     o_den,
    output logic [QUO_W-1:0] o_num,
    output logic [QUO_W-1:0] o_quo
);

    logic [W:0]       w_rem2;
    logic             w_ge;
    logic [W-1:0]     n_rem;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_den;
    logic [QUO_W-1:0] r_num;
    logic [QUO_W-1:0] r_quo;

    always_comb begin
        w_rem2 = {i_rem, i_num[QUO_W-1]};
        w_ge   = (w_rem2 >= {1'b0, i_den});
        n_rem  = w_ge ? W'(w_rem2 - {1'b0, i_den}) : W'(w_rem2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_num <= {i_num[QUO_W-2:0], 1'b0};
            r_quo <= {i_quo[QUO_W-2:0], w_ge};
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_num = r_num;
    assign o_quo = r_quo;

endmodule

@@ hdl/gamepad_deadzone_conditioner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_deadzone_conditioner
// Conditions one controller report per cycle: radial dead zone on both
// sticks, threshold remap on both triggers, buttons passed through. Fully
// pipelined: one item enters every cycle unless the pipe halts, and each
// item passes 37 register stages (capture with squaring, sum, a 16-cell
// square root chain, two multiply stages, a 16-cell divider chain, output
// register) before its result is offered. The whole pipe halts only
// while a finished item waits at the output under stall.
// Dead zone and threshold registers are read live, so write them only
// while the pipe is empty.
// ----------------------------------------------------------------------------
module gamepad_deadzone_conditioner import gdc_pkg::*; #(
    parameter int AXIS_FULL_SCALE = AXIS_FULL_SCALE_DEF,
    parameter int NUM_SLOTS       = NUM_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_controller_index,
    input  logic                i_connected,
    input  logic [AXIS_W-1:0]   i_left_stick_x,
    input  logic [AXIS_W-1:0]   i_left_stick_y,
    input  logic [AXIS_W-1:0]   i_right_stick_x,
    input  logic [AXIS_W-1:0]   i_right_stick_y,
    input  logic [TRIG_W-1:0]   i_left_trigger,
    input  logic [TRIG_W-1:0]   i_right_trigger,
    input  logic [15:0]         i_button_mask,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_slot,
    output logic                o_present,
    output logic [AXIS_W-1:0]   o_left_x,
    output logic [AXIS_W-1:0]   o_left_y,
    output logic [AXIS_W-1:0]   o_right_x,
    output logic [AXIS_W-1:0]   o_right_y,
    output logic [15:0]         o_left_pull,
    output logic [15:0]         o_right_pull,
    output logic [15:0]         o_pressed_buttons
);

    localparam logic [DZ_W-1:0] FS = DZ_W'(AXIS_FULL_SCALE);
    localparam int STEPS = QUO_W;

    logic w_adv;

    logic [DZ_W-1:0]   r_dz [NUM_STICK];
    logic [TRIG_W-1:0] r_thr;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz[0] <= LEFT_DZ_RST;
            r_dz[1] <= RIGHT_DZ_RST;
            r_thr   <= TRIG_THR_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_LEFT_DZ:  r_dz[0] <= i_cfg_wdata;
                REG_RIGHT_DZ: r_dz[1] <= i_cfg_wdata;
                REG_TRIG_THR: r_thr   <= i_cfg_wdata[TRIG_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_adv      = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_adv;

    // capture, square and sum
    t_side              w_in;
    logic signed [31:0] w_sq [NUM_AXIS];
    logic [30:0]        r_sq [NUM_AXIS];
    t_side              r_side1;
    logic [SQ_VAL_W-1:0] r_sum [NUM_STICK];
    t_side              r_side2;

    always_comb begin
        w_in.valid   = i_in_valid;
        w_in.slot    = i_controller_index;
        w_in.present = i_connected && ({3'b000, i_controller_index} < 5'(NUM_SLOTS));
        w_in.axis[0] = i_left_stick_x;
        w_in.axis[1] = i_left_stick_y;
        w_in.axis[2] = i_right_stick_x;
        w_in.axis[3] = i_right_stick_y;
        w_in.trig[0] = i_left_trigger;
        w_in.trig[1] = i_right_trigger;
        w_in.buttons = i_button_mask;
        for (int a = 0; a < NUM_AXIS; a++) begin
            w_sq[a] = $signed(w_in.axis[a]) * $signed(w_in.axis[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side1.valid <= 1'b0;
            r_side2.valid <= 1'b0;
        end else if (w_adv) begin
            r_side1 <= w_in;
            for (int a = 0; a < NUM_AXIS; a++) begin
                r_sq[a] <= w_sq[a][30:0];
            end
            r_side2 <= r_side1;
            for (int s = 0; s < NUM_STICK; s++) begin
                r_sum[s] <= {1'b0, r_sq[2*s]} + {1'b0, r_sq[2*s+1]};
            end
        end
    end

    // square root chain
    logic [SQ_REM_W-1:0] w_sr_rem  [NUM_STICK][STEPS+1];
    logic [ROOT_W-1:0]   w_sr_root [NUM_STICK][STEPS+1];
    logic [SQ_VAL_W-1:0] w_sr_val  [NUM_STICK][STEPS+1];
    t_side               r_sq_side [STEPS];

    genvar gs, gk, ga, gt;
    generate
        for (gs = 0; gs < NUM_STICK; gs++) begin : g_sqrt
            assign w_sr_rem[gs][0]  = '0;
            assign w_sr_root[gs][0] = '0;
            assign w_sr_val[gs][0]  = r_sum[gs];
            for (gk = 0; gk < STEPS; gk++) begin : g_cell
                gdc_sqrt_cell u_cell (
                    .i_clk  (i_clk),
                    .i_en   (w_adv),
                    .i_rem  (w_sr_rem[gs][gk]),
                    .i_root (w_sr_root[gs][gk]),
                    .i_val  (w_sr_val[gs][gk]),
                    .o_rem  (w_sr_rem[gs][gk+1]),
                    .o_root (w_sr_root[gs][gk+1]),
                    .o_val  (w_sr_val[gs][gk+1])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STEPS; k++) begin
                r_sq_side[k].valid <= 1'b0;
            end
        end else if (w_adv) begin
            r_sq_side[0] <= r_side2;
            for (int k = 1; k < STEPS; k++) begin
                r_sq_side[k] <= r_sq_side[k-1];
            end
        end
    end

    // stage c: magnitudes, distance past dead zone, products, divisor
    t_side             w_cs;
    logic [ROOT_W-1:0] w_len  [NUM_STICK];
    logic              w_out_dz [NUM_STICK];
    logic [ROOT_W-1:0] w_past [NUM_STICK];
    logic [ROOT_W-1:0] w_fsd  [NUM_STICK];
    logic [AXIS_W-1:0] w_mag  [NUM_AXIS];
    t_meta             w_cmeta;
    logic [31:0]       r_c_prod [NUM_AXIS];
    logic [DEN_W-1:0]  r_c_den  [NUM_STICK];
    t_meta             r_c_meta;

    always_comb begin
        w_cs = r_sq_side[STEPS-1];
        w_cmeta = '0;
        w_cmeta.valid   = w_cs.valid;
        w_cmeta.slot    = w_cs.slot;
        w_cmeta.present = w_cs.present;
        w_cmeta.trig    = w_cs.trig;
        w_cmeta.buttons = w_cs.buttons;
        for (int s = 0; s < NUM_STICK; s++) begin
            w_len[s]    = w_sr_root[s][STEPS];
            w_out_dz[s] = w_len[s] > {1'b0, r_dz[s]};
            w_past[s]   = w_len[s] - {1'b0, r_dz[s]};
            w_fsd[s]    = {1'b0, FS} - {1'b0, r_dz[s]};
            w_cmeta.sat[s] = (r_dz[s] >= FS);
        end
        for (int a = 0; a < NUM_AXIS; a++) begin
            w_cmeta.neg[a]  = w_cs.axis[a][AXIS_W-1];
            w_mag[a]        = w_cmeta.neg[a] ? AXIS_W'(16'd0 - w_cs.axis[a])
                                             : w_cs.axis[a];
            w_cmeta.zero[a] = !w_out_dz[a/2] || (w_mag[a] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_meta.valid <= 1'b0;
        end else if (w_adv) begin
            r_c_meta <= w_cmeta;
            for (int a = 0; a < NUM_AXIS; a++) begin
                r_c_prod[a] <= w_mag[a] * w_past[a/2];
            end
            for (int s = 0; s < NUM_STICK; s++) begin
                r_c_den[s] <= w_len[s] * w_fsd[s][DZ_W-1:0];
            end
        end
    end

    // stage d: scale numerator, trigger operands
    logic [TRIG_W-1:0] w_tdiff [NUM_STICK];
    t_meta             w_dmeta;
    logic [NUM_W-1:0]  r_d_num  [NUM_AXIS];
    logic [DEN_W-1:0]  r_d_den  [NUM_STICK];
    logic [TNUM_W-1:0] r_d_tnum [NUM_STICK];
    logic [TRIG_W-1:0] r_d_tden;
    t_meta             r_d_meta;

    always_comb begin
        w_dmeta = r_c_meta;
        for (int s = 0; s < NUM_STICK; s++) begin
            w_tdiff[s]       = r_c_meta.trig[s] - r_thr;
            w_dmeta.tzero[s] = (r_c_meta.trig[s] <= r_thr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_meta.valid <= 1'b0;
        end else if (w_adv) begin
            r_d_meta <= w_dmeta;
            for (int a = 0; a < NUM_AXIS; a++) begin
                r_d_num[a] <= r_c_prod[a] * FS;
            end
            for (int s = 0; s < NUM_STICK; s++) begin
                r_d_den[s]  <= r_c_den[s];
                r_d_tnum[s] <= {w_tdiff[s], 16'd0} - {16'd0, w_tdiff[s]};
            end
            r_d_tden <= TRIG_TOP - r_thr;
        end
    end

    // divider chains
    logic [DEN_W-1:0]  w_dv_rem [NUM_AXIS][STEPS+1];
    logic [DEN_W-1:0]  w_dv_den [NUM_AXIS][STEPS+1];
    logic [QUO_W-1:0]  w_dv_num [NUM_AXIS][STEPS+1];
    logic [QUO_W-1:0]  w_dv_quo [NUM_AXIS][STEPS+1];
    logic [TRIG_W-1:0] w_tv_rem [NUM_STICK][STEPS+1];
    logic [TRIG_W-1:0] w_tv_den [NUM_STICK][STEPS+1];
    logic [QUO_W-1:0]  w_tv_num [NUM_STICK][STEPS+1];
    logic [QUO_W-1:0]  w_tv_quo [NUM_STICK][STEPS+1];

    generate
        for (ga = 0; ga < NUM_AXIS; ga++) begin : g_adiv
            assign w_dv_rem[ga][0] = r_d_num[ga][NUM_W-1:QUO_W];
            assign w_dv_den[ga][0] = r_d_den[ga/2];
            assign w_dv_num[ga][0] = r_d_num[ga][QUO_W-1:0];
            assign w_dv_quo[ga][0] = '0;
            for (gk = 0; gk < STEPS; gk++) begin : g_cell
                gdc_div_cell #(.W(DEN_W)) u_cell (
                    .i_clk (i_clk),
                    .i_en  (w_adv),
                    .i_rem (w_dv_rem[ga][gk]),
                    .i_den (w_dv_den[ga][gk]),
                    .i_num (w_dv_num[ga][gk]),
                    .i_quo (w_dv_quo[ga][gk]),
                    .o_rem (w_dv_rem[ga][gk+1]),
                    .o_den (w_dv_den[ga][gk+1]),
                    .o_num (w_dv_num[ga][gk+1]),
                    .o_quo (w_dv_quo[ga][gk+1])
                );
            end
        end
        for (gt = 0; gt < NUM_STICK; gt++) begin : g_tdiv
            assign w_tv_rem[gt][0] = r_d_tnum[gt][TNUM_W-1:QUO_W];
            assign w_tv_den[gt][0] = r_d_tden;
            assign w_tv_num[gt][0] = r_d_tnum[gt][QUO_W-1:0];
            assign w_tv_quo[gt][0] = '0;
            for (gk = 0; gk < STEPS; gk++) begin : g_cell
                gdc_div_cell #(.W(TRIG_W)) u_cell (
                    .i_clk (i_clk),
                    .i_en  (w_adv),
                    .i_rem (w_tv_rem[gt][gk]),
                    .i_den (w_tv_den[gt][gk]),
                    .i_num (w_tv_num[gt][gk]),
                    .i_quo (w_tv_quo[gt][gk]),
                    .o_rem (w_tv_rem[gt][gk+1]),
                    .o_den (w_tv_den[gt][gk+1]),
                    .o_num (w_tv_num[gt][gk+1]),
                    .o_quo (w_tv_quo[gt][gk+1])
                );
            end
        end
    endgenerate

    // quotient would not fit in 16 bits
    t_meta w_emeta;
    t_meta r_dv_meta [STEPS];

    always_comb begin
        w_emeta = r_d_meta;
        for (int a = 0; a < NUM_AXIS; a++) begin
            w_emeta.ovf[a] = (r_d_num[a][NUM_W-1:QUO_W] >= r_d_den[a/2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STEPS; k++) begin
                r_dv_meta[k].valid <= 1'b0;
            end
        end else if (w_adv) begin
            r_dv_meta[0] <= w_emeta;
            for (int k = 1; k < STEPS; k++) begin
                r_dv_meta[k] <= r_dv_meta[k-1];
            end
        end
    end

    // output stage: clamp, sign, zero
    t_meta             w_fm;
    logic [QUO_W-1:0]  w_q     [NUM_AXIS];
    logic [AXIS_W-1:0] n_axis  [NUM_AXIS];
    logic [15:0]       n_pull  [NUM_STICK];
    logic [AXIS_W-1:0] r_axis  [NUM_AXIS];
    logic [15:0]       r_pull  [NUM_STICK];
    logic              r_out_valid;
    logic [1:0]        r_slot;
    logic              r_present;
    logic [15:0]       r_buttons;

    always_comb begin
        w_fm = r_dv_meta[STEPS-1];
        for (int a = 0; a < NUM_AXIS; a++) begin
            if (w_fm.sat[a/2] || w_fm.ovf[a] || (w_dv_quo[a][STEPS] > {1'b0, FS})) begin
                w_q[a] = {1'b0, FS};
            end else begin
                w_q[a] = w_dv_quo[a][STEPS];
            end
            if (!w_fm.present || w_fm.zero[a]) begin
                n_axis[a] = '0;
            end else if (w_fm.neg[a]) begin
                n_axis[a] = AXIS_W'(16'd0 - w_q[a]);
            end else begin
                n_axis[a] = w_q[a];
            end
        end
        for (int s = 0; s < NUM_STICK; s++) begin
            n_pull[s] = (!w_fm.present || w_fm.tzero[s]) ? 16'd0 : w_tv_quo[s][STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_fm.valid;
            r_slot      <= w_fm.slot;
            r_present   <= w_fm.present;
            r_buttons   <= w_fm.present ? w_fm.buttons : 16'd0;
            for (int a = 0; a < NUM_AXIS; a++) begin
                r_axis[a] <= n_axis[a];
            end
            for (int s = 0; s < NUM_STICK; s++) begin
                r_pull[s] <= n_pull[s];
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_slot            = r_slot;
    assign o_present         = r_present;
    assign o_left_x          = r_axis[0];
    assign o_left_y          = r_axis[1];
    assign o_right_x         = r_axis[2];
    assign o_right_y         = r_axis[3];
    assign o_left_pull       = r_pull[0];
    assign o_right_pull      = r_pull[1];
    assign o_pressed_buttons = r_buttons;

endmodule

@@ tb/gamepad_deadzone_conditioner_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_deadzone_conditioner_tb
// Drives controller reports through the conditioner under random idling on
// both sides, predicts each result from an independent model of the dead
// zone and trigger math, and checks every output field in order.
// ----------------------------------------------------------------------------
module gamepad_deadzone_conditioner_tb;
    import gdc_pkg::*;

    localparam int FS = 32767;
    localparam int PIPE_DEPTH = 37;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  slot;
        logic        present;
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] rx;
        logic [15:0] ry;
        logic [15:0] lpull;
        logic [15:0] rpull;
        logic [15:0] buttons;
    } t_report_out;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [1:0]        i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_wdata;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_controller_index;
    logic              i_connected;
    logic [15:0]       i_left_stick_x;
    logic [15:0]       i_left_stick_y;
    logic [15:0]       i_right_stick_x;
    logic [15:0]       i_right_stick_y;
    logic [7:0]        i_left_trigger;
    logic [7:0]        i_right_trigger;
    logic [15:0]       i_button_mask;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [1:0]        o_slot;
    logic              o_present;
    logic [15:0]       o_left_x;
    logic [15:0]       o_left_y;
    logic [15:0]       o_right_x;
    logic [15:0]       o_right_y;
    logic [15:0]       o_left_pull;
    logic [15:0]       o_right_pull;
    logic [15:0]       o_pressed_buttons;

    gamepad_deadzone_conditioner i_dut (.*);

    longint unsigned left_dz;
    longint unsigned right_dz;
    longint unsigned trig_thr;
    t_report_out     expected_reports[$];
    int              mismatches;
    int              idle_pct;
    int              quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) begin
                r = r | (64'd1 << b);
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] axis_out(longint a, longint unsigned len,
                                             longint unsigned dz);
        longint unsigned mag;
        longint unsigned q;
        mag = (a < 0) ? -a : a;
        if (mag == 0) return 16'd0;
        if (dz >= FS) begin
            q = FS;
        end else begin
            q = (mag * (len - dz) * FS) / (len * (FS - dz));
            if (q > FS) q = FS;
        end
        return (a < 0) ? 16'(-longint'(q)) : 16'(q);
    endfunction

    function automatic void stick_out(logic [15:0] rx, logic [15:0] ry,
                                      longint unsigned dz,
                                      output logic [15:0] ox, output logic [15:0] oy);
        longint x;
        longint y;
        longint unsigned len;
        x = longint'($signed(rx));
        y = longint'($signed(ry));
        len = isqrt(x * x + y * y);
        if (len <= dz) begin
            ox = 0;
            oy = 0;
        end else begin
            ox = axis_out(x, len, dz);
            oy = axis_out(y, len, dz);
        end
    endfunction

    function automatic logic [15:0] pull_out(logic [7:0] t);
        if (t <= trig_thr || trig_thr >= 255) return 16'd0;
        return 16'(((t - trig_thr) * 65535) / (255 - trig_thr));
    endfunction

    function automatic t_report_out condition_report(logic [1:0] idx, logic conn,
            logic [15:0] lx, logic [15:0] ly, logic [15:0] rx, logic [15:0] ry,
            logic [7:0] lt, logic [7:0] rt, logic [15:0] btn);
        t_report_out r;
        r = '0;
        r.slot = idx;
        if (conn) begin
            r.present = 1'b1;
            stick_out(lx, ly, left_dz, r.lx, r.ly);
            stick_out(rx, ry, right_dz, r.rx, r.ry);
            r.lpull = pull_out(lt);
            r.rpull = pull_out(rt);
            r.buttons = btn;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // result checker and stall driver
    always @(posedge i_clk) begin
        t_report_out w;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("unexpected item", 1, 0);
                end else begin
                    w = expected_reports.pop_front();
                    if (o_slot !== w.slot) report_mismatch("slot", o_slot, w.slot);
                    if (o_present !== w.present)
                        report_mismatch("present", o_present, w.present);
                    if (o_left_x !== w.lx) report_mismatch("left_x", o_left_x, w.lx);
                    if (o_left_y !== w.ly) report_mismatch("left_y", o_left_y, w.ly);
                    if (o_right_x !== w.rx) report_mismatch("right_x", o_right_x, w.rx);
                    if (o_right_y !== w.ry) report_mismatch("right_y", o_right_y, w.ry);
                    if (o_left_pull !== w.lpull)
                        report_mismatch("left_pull", o_left_pull, w.lpull);
                    if (o_right_pull !== w.rpull)
                        report_mismatch("right_pull", o_right_pull, w.rpull);
                    if (o_pressed_buttons !== w.buttons)
                        report_mismatch("buttons", o_pressed_buttons, w.buttons);
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < idle_pct);
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // valid stays high after an accepted item until the next idle or drain
    task automatic send_report(logic [1:0] idx, logic conn, logic [15:0] lx,
            logic [15:0] ly, logic [15:0] rx, logic [15:0] ry, logic [7:0] lt,
            logic [7:0] rt, logic [15:0] btn);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_controller_index <= idx;
        i_connected        <= conn;
        i_left_stick_x     <= lx;
        i_left_stick_y     <= ly;
        i_right_stick_x    <= rx;
        i_right_stick_y    <= ry;
        i_left_trigger     <= lt;
        i_right_trigger    <= rt;
        i_button_mask      <= btn;
        expected_reports.push_back(condition_report(idx, conn, lx, ly, rx, ry, lt, rt,
                                                    btn));
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= CFG_W'(value);
        @(posedge i_clk);
        case (idx)
            REG_LEFT_DZ:  left_dz  = value & 16'h7fff;
            REG_RIGHT_DZ: right_dz = value & 16'h7fff;
            REG_TRIG_THR: trig_thr = value & 8'hff;
            default: ;
        endcase
    endtask

    task automatic set_config(int ldz, int rdz, int thr);
        drain_pipe();
        write_reg(REG_LEFT_DZ, ldz);
        write_reg(REG_RIGHT_DZ, rdz);
        write_reg(REG_TRIG_THR, thr);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(200)) - 16'd100;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_trig();
        case ($urandom_range(4))
            0: return 8'd255;
            1: return 8'(trig_thr + $urandom_range(2)) - 8'd1;
            2: return 8'd0;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random(int count);
        for (int n = 0; n < count; n++) begin
            send_report(2'($urandom), ($urandom_range(9) != 0), rand_axis(), rand_axis(),
                        rand_axis(), rand_axis(), rand_trig(), rand_trig(),
                        16'($urandom));
        end
    endtask

    task automatic test_directed_extremes();
        send_report(2'd0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0,
                    16'h0000);
        send_report(2'd3, 1'b1, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 8'd255, 8'd255,
                    16'hffff);
        send_report(2'd1, 1'b1, 16'h8000, 16'h0000, 16'h0000, 16'h7fff, 8'd30, 8'd31,
                    16'ha5a5);
        send_report(2'd2, 1'b0, 16'h7fff, 16'h8000, 16'h1234, 16'hfedc, 8'd200, 8'd99,
                    16'h5a5a);
        // right at the dead zone edge
        send_report(2'd1, 1'b1, 16'd7849, 16'h0000, 16'h0000, 16'd8690, 8'd29, 8'd254,
                    16'h0001);
        send_report(2'd0, 1'b1, 16'd7850, 16'hffff, 16'hffff, 16'hffff, 8'd128, 8'd1,
                    16'h8000);
    endtask

    task automatic test_register_extremes();
        set_config(0, 0, 0);
        test_directed_extremes();
        set_config(32766, 32767, 254);
        test_directed_extremes();
        set_config(1, 16000, 255);
        test_directed_extremes();
    endtask

    task automatic test_random_reports();
        set_config(7849, 8689, 30);
        idle_pct = 0;
        send_random(150);
        idle_pct = 23;
        send_random(350);
        // sender holds off until everything has come back
        drain_pipe();
        set_config($urandom_range(32766), $urandom_range(32766), $urandom_range(254));
        send_random(300);
        set_config($urandom_range(2000), $urandom_range(30000, 32766), $urandom_range(20));
        send_random(200);
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_wr_en        <= 1'b0;
        i_cfg_index        <= REG_LEFT_DZ;
        i_cfg_wdata        <= '0;
        i_in_valid         <= 1'b0;
        i_out_stall        <= 1'b0;
        i_controller_index <= '0;
        i_connected        <= 1'b0;
        i_left_stick_x     <= '0;
        i_left_stick_y     <= '0;
        i_right_stick_x    <= '0;
        i_right_stick_y    <= '0;
        i_left_trigger     <= '0;
        i_right_trigger    <= '0;
        i_button_mask      <= '0;
        left_dz            = 7849;
        right_dz           = 8689;
        trig_thr           = 30;
        mismatches         = 0;
        idle_pct           = 23;
        quiet_cycles       = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_register_extremes();
        test_random_reports();
        drain_pipe();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
